/* design/ptt_pkg.sv */
// Package for the periodic timer table: shared constants, operation and
// result codes, the slot entry layout and the result struct.
// No dependencies.
package ptt_pkg;

    // Default table depth and reset value of the minimum period register
    localparam int          SLOTS_DEFAULT    = 64;
    localparam logic [31:0] MIN_PERIOD_RESET = 32'd100;

    // Request operation codes
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_KILL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_KILL   = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    // One slot of the timer table; id zero marks a free slot
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] period;
        logic [63:0] last_fire;
    } t_entry;

    // Result transfer from the scan engine to the output register
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] id;
        logic        ok;
        logic        last;
    } t_result;

endpackage

/* design/ptt_engine.sv */
// Scan engine of the periodic timer table: slot memory, millisecond counter
// and the sequencer that walks the slots once per request.
// Depends on ptt_pkg.
module ptt_engine #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_min_period,
    input  logic             i_start,
    input  logic [1:0]       i_op,
    input  logic [31:0]      i_timer_id,
    input  logic [31:0]      i_period_ms,
    input  logic             i_out_free,
    output logic             o_busy,
    output ptt_pkg::t_result o_emit
);
    import ptt_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_ev_addr;
    logic          r_rd_pend;
    logic [1:0]    r_op;
    logic [31:0]   r_id;
    logic [31:0]   r_period;
    logic          r_found;
    logic          r_matched;
    logic [63:0]   r_now;
    logic          r_pend_valid;
    logic [31:0]   r_pend_id;

    t_entry        mem [SLOTS];
    t_entry        r_rd_data;

    logic [63:0]   elapsed;
    logic [63:0]   next_last;
    logic          due;
    logic          hit;
    logic          is_free;
    logic          wr_want;
    t_entry        ev_data;
    logic          fire;
    logic          hold;
    logic          eval_go;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          done_emit;
    logic          done_go;
    logic          req_ok;

    // Evaluate the slot whose read data is present
    assign elapsed   = r_now - r_rd_data.last_fire;
    assign next_last = r_rd_data.last_fire + {32'd0, r_rd_data.period};
    assign due       = elapsed >= {32'd0, r_rd_data.period};
    assign hit       = r_rd_data.id == r_id;
    assign is_free   = r_rd_data.id == 32'd0;

    always_comb begin
        wr_want = 1'b0;
        fire    = 1'b0;
        ev_data = '0;
        unique case (r_op)
            OP_SET: begin
                if (!r_found && (is_free || hit)) begin
                    wr_want           = 1'b1;
                    ev_data.id        = r_id;
                    ev_data.period    = r_period;
                    ev_data.last_fire = r_now;
                end else if (r_found && !r_matched && hit) begin
                    wr_want = 1'b1;
                end
            end
            OP_KILL: begin
                wr_want = !r_found && hit;
            end
            OP_TICK: begin
                if (!is_free && due) begin
                    wr_want           = 1'b1;
                    fire              = 1'b1;
                    ev_data.id        = r_rd_data.id;
                    ev_data.period    = r_rd_data.period;
                    ev_data.last_fire = next_last;
                end
            end
            default: begin
                wr_want = 1'b0;
            end
        endcase
    end

    // Hold the scan while a firing slot cannot hand its predecessor on
    assign hold    = r_rd_pend && fire && r_pend_valid && !i_out_free;
    assign eval_go = (r_state == S_SCAN) && r_rd_pend && !hold;
    assign rd_en   = (r_state == S_SCAN) && !hold && (r_cnt != SLOTS_CNT);

    // Memory write port: clearing pass or write-back of the evaluated slot
    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[AW-1:0];
            wr_data = '0;
        end else begin
            wr_en   = eval_go && wr_want;
            wr_addr = r_ev_addr;
            wr_data = ev_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_cnt[AW-1:0]];
        end
    end

    // Result selection: expiries during the scan, final result at the end
    assign done_emit = (r_op == OP_SET) || (r_op == OP_KILL) ||
                       ((r_op == OP_TICK) && r_pend_valid);
    assign done_go   = i_out_free || !done_emit;

    always_comb begin
        o_emit = '0;
        if (eval_go && fire && r_pend_valid) begin
            o_emit.valid = 1'b1;
            o_emit.kind  = KIND_EXPIRY;
            o_emit.id    = r_pend_id;
            o_emit.ok    = 1'b1;
            o_emit.last  = 1'b0;
        end else if ((r_state == S_DONE) && done_emit && i_out_free) begin
            o_emit.valid = 1'b1;
            o_emit.last  = 1'b1;
            if (r_op == OP_TICK) begin
                o_emit.kind = KIND_EXPIRY;
                o_emit.id   = r_pend_id;
                o_emit.ok   = 1'b1;
            end else begin
                o_emit.kind = (r_op == OP_SET) ? KIND_SET : KIND_KILL;
                o_emit.id   = r_id;
                o_emit.ok   = r_found;
            end
        end
    end

    // Refuse a set with id zero or a short period, a kill with id zero, and the unused operation code
    always_comb begin
        unique case (i_op)
            OP_SET:  req_ok = (i_timer_id != 32'd0) && (i_period_ms >= i_min_period);
            OP_KILL: req_ok = i_timer_id != 32'd0;
            OP_TICK: req_ok = 1'b1;
            default: req_ok = 1'b0;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_rd_pend    <= 1'b0;
            r_found      <= 1'b0;
            r_matched    <= 1'b0;
            r_now        <= 64'd0;
            r_pend_valid <= 1'b0;
            r_op         <= OP_SET;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt[AW-1:0] == LAST_ADDR) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op      <= i_op;
                        r_id      <= i_timer_id;
                        r_period  <= i_period_ms;
                        r_found   <= 1'b0;
                        r_matched <= 1'b0;
                        r_cnt     <= '0;
                        r_rd_pend <= 1'b0;
                        if (i_op == OP_TICK) begin
                            r_now <= r_now + 64'd1;
                        end
                        r_state <= req_ok ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    // Advance the read pointer one slot per cycle unless the scan is held
                    if (rd_en) begin
                        r_cnt     <= r_cnt + CW'(1);
                        r_ev_addr <= r_cnt[AW-1:0];
                        r_rd_pend <= 1'b1;
                    end else if (!hold) begin
                        r_rd_pend <= 1'b0;
                    end
                    // Track set and kill progress and park the latest expiry
                    if (eval_go && wr_want) begin
                        if (r_op == OP_SET) begin
                            if (!r_found) begin
                                r_found   <= 1'b1;
                                r_matched <= hit;
                            end else begin
                                r_matched <= 1'b1;
                            end
                        end else if (r_op == OP_KILL) begin
                            r_found <= 1'b1;
                        end
                    end
                    if (eval_go && fire) begin
                        r_pend_valid <= 1'b1;
                        r_pend_id    <= r_rd_data.id;
                    end
                    if (!r_rd_pend && (r_cnt == SLOTS_CNT)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_go) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> i_out_free)
        else $error("result issued while the output register is occupied");

    a_no_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != r_cnt[AW-1:0]))
        else $error("read and write hit the same slot in one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("engine not busy after accepting a request");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.last && (o_emit.kind == KIND_EXPIRY)) |=> !r_pend_valid)
        else $error("pending expiry kept after the final expiry");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == S_SCAN))
        else $error("slot read data pending outside the scan");

endmodule

/* design/periodic_timer_table_top.sv */
// Top level of the periodic timer table: request and result channels,
// minimum period register and output register around the scan engine.
// Depends on ptt_pkg and ptt_engine.

// The table holds SLOTS periodic timers in one synchronous memory that is
// read and written back one slot per cycle unless the scan is held. After
// reset a clearing pass zeroes the memory; requests are stalled until it
// is done, while the minimum period write channel is always ready. A set,
// kill or tick request walks every slot once; no new request is taken
// until its reply or final expiry has been loaded into the output
// register. The scan and the final result wait while the consumer stalls
// a full result register and a result is waiting; without result stalls
// expiries do not slow the scan. A refused set or kill (id zero or period
// below the minimum) and the unused operation code skip the scan. A set
// or kill gives one reply; a tick gives one expiry per firing timer in
// slot order, possibly none, with last marking the final one.
module periodic_timer_table_top #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_timer_id,
    input  logic [31:0] i_period_ms,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_fired_or_target_id,
    output logic        o_ok,
    output logic        o_last,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_min_period_ms
);
    import ptt_pkg::*;

    logic        r_min_period;
    logic [31:0] r_min_period_ms;
    logic        r_o_valid;
    logic [1:0]  r_o_kind;
    logic [31:0] r_o_id;
    logic        r_o_ok;
    logic        r_o_last;
    logic        busy;
    logic        start;
    logic        out_free;
    t_result     emit;

    // Minimum period register, written at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period_ms <= MIN_PERIOD_RESET;
            r_min_period    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_period_ms <= i_cfg_min_period_ms;
            r_min_period    <= 1'b1;
        end
    end

    // Request transfer
    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;

    ptt_engine #(
        .SLOTS(SLOTS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_min_period (r_min_period_ms),
        .i_start      (start),
        .i_op         (i_op),
        .i_timer_id   (i_timer_id),
        .i_period_ms  (i_period_ms),
        .i_out_free   (out_free),
        .o_busy       (busy),
        .o_emit       (emit)
    );

    // Output register: load when empty or being taken
    assign out_free = !r_o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit.valid) begin
            r_o_kind <= emit.kind;
            r_o_id   <= emit.id;
            r_o_ok   <= emit.ok;
            r_o_last <= emit.last;
        end
    end

    assign o_out_valid          = r_o_valid;
    assign o_kind               = r_o_kind;
    assign o_fired_or_target_id = r_o_id;
    assign o_ok                 = r_o_ok;
    assign o_last               = r_o_last;

    // A register write while requests are in flight is outside the contract
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min_period && $changed(r_min_period_ms)) |-> $past(!busy || !r_min_period))
        else $error("minimum period changed while a request was in flight");

endmodule
